### rtl/core/csr_sparse_matrix_vector_multiply_macros.svh
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_macros.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSMV_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CSMV_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

### rtl/core/csrspmv_pkg.sv
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Types and constants of the CSR sparse matrix times vector block.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

  localparam int OP_W       = 2;
  localparam int INDEX_W    = 10;
  localparam int VALUE_W    = 32;
  localparam int ROW_W      = 16;
  localparam int ACC_W      = 64;
  localparam int FRAC_W     = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
  localparam logic [OP_W-1:0] OP_EMPTY   = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SUM_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic load_we;
    logic rd_en;
    logic mul_en;
    logic acc_en;
    logic emit;
    logic emit_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/csrspmv_ctrl.sv
// ----------------------------------------------------------------------------
// csrspmv_ctrl
// Sequencer that writes loads to the store, steps each nonzero through read,
// multiply and accumulate, and hands off a result at a row end or empty row.
// ----------------------------------------------------------------------------
module csrspmv_ctrl
  import csrspmv_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  input  logic            in_last,
  input  dp_status_t      status,
  output logic            in_ready,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   last, last_next;
  logic   zero_row, zero_row_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    last_next     = last;
    zero_row_next = zero_row;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_LOAD: begin
              cmd.load_we = 1'b1;
            end
            OP_NONZERO: begin
              cmd.rd_en     = 1'b1;
              last_next     = in_last;
              zero_row_next = 1'b0;
              state_next    = ST_MUL;
            end
            OP_EMPTY: begin
              zero_row_next = 1'b1;
              state_next    = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_zero = zero_row;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      last     <= 1'b0;
      zero_row <= 1'b0;
    end else begin
      state    <= state_next;
      last     <= last_next;
      zero_row <= zero_row_next;
    end
  end

endmodule

### rtl/core/csrspmv_dp.sv
// ----------------------------------------------------------------------------
// csrspmv_dp
// Vector store, multiplier, saturating accumulator, row counter and
// result register.
// ----------------------------------------------------------------------------
module csrspmv_dp
  import csrspmv_pkg::*;
#(
  parameter int VECTOR_DEPTH = 1024,
  parameter int MAX_ROWS     = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [INDEX_W-1:0] in_index,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_ready,
  output dp_status_t         status,
  output logic               out_valid,
  output logic [ROW_W-1:0]   out_row,
  output logic [VALUE_W-1:0] out_sum,
  output logic               out_sat
);

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int CW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [VALUE_W-1:0] mem [0:VECTOR_DEPTH-1];

  logic [CW-1:0]             idx_ext;
  logic                      in_range;
  logic [AW-1:0]             addr;
  logic [VALUE_W-1:0]        rd_data;
  logic                      x_valid;
  logic signed [VALUE_W-1:0] val_reg;
  logic signed [VALUE_W-1:0] x_sel;
  logic signed [ACC_W-1:0]   product;
  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [ACC_W-1:0]   acc;
  logic                      over_hi;
  logic                      over_lo;
  logic [RW-1:0]             row_cnt;

  assign idx_ext  = CW'(in_index);
  assign in_range = idx_ext < CW'(VECTOR_DEPTH);
  assign addr     = idx_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_we && in_range) begin
      mem[addr] <= in_value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
      x_valid <= in_range;
      val_reg <= in_value;
    end
  end

  assign x_sel = x_valid ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product <= val_reg * x_sel;
    end
  end

  assign addend = product >>> FRAC_W;
  assign sum    = acc + addend;

  always_comb begin
    acc_sat = sum;
    if ((acc[ACC_W-1] == addend[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1])) begin
      acc_sat = acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  assign over_hi = acc > SUM_MAX;
  assign over_lo = acc < SUM_MIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      row_cnt <= '0;
    end else begin
      if (cmd.acc_en) begin
        acc <= acc_sat;
      end else if (cmd.emit && !cmd.emit_zero) begin
        acc <= '0;
      end
      if (cmd.emit) begin
        row_cnt <= (row_cnt == RW'(MAX_ROWS - 1)) ? '0 : row_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row <= ROW_W'(row_cnt);
      if (cmd.emit_zero) begin
        out_sum <= '0;
        out_sat <= 1'b0;
      end else if (over_hi) begin
        out_sum <= SUM_MAX[VALUE_W-1:0];
        out_sat <= 1'b1;
      end else if (over_lo) begin
        out_sum <= SUM_MIN[VALUE_W-1:0];
        out_sat <= 1'b1;
      end else begin
        out_sum <= acc[VALUE_W-1:0];
        out_sat <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

### rtl/core/csr_sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// CSR sparse matrix times dense vector in signed Q16.16 with saturated
// row sums.
// ----------------------------------------------------------------------------
//   Port group  Direction  Carries
//   s_axis      in         load, nonzero or empty-row request
//   m_axis      out        finished row number, row sum and clip flag
//
// A load writes the store; a nonzero runs store read, multiply and
// accumulate, plus emit at a row end; an empty row goes straight to emit.
// The store read, the multiplier register and the accumulator step run
// in sequence, so one request is in flight at a time.
// Reset clears the sum, row counter and output valid flag, not the vector
// store or result data. A result that is still held delays the emit step
// of the next result, and later requests wait until it is done.
module csr_sparse_matrix_vector_multiply
  import csrspmv_pkg::*;
#(
  parameter int VECTOR_DEPTH = 1024,
  parameter int MAX_ROWS     = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // index, value
  input  logic [OP_W-1:0]       s_axis_tuser,   // operation
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // row_number, row_sum
  output logic                  m_axis_tuser    // saturated
);

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic [ROW_W-1:0]   out_row;
  logic [VALUE_W-1:0] out_sum;

  csrspmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  csrspmv_dp #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .MAX_ROWS     (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_index  (s_axis_tdata[INDEX_W-1:0]),
    .in_value  (s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .out_ready (m_axis_tready),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_row   (out_row),
    .out_sum   (out_sum),
    .out_sat   (m_axis_tuser)
  );

  assign m_axis_tdata = {out_sum, out_row};

endmodule

### rtl/core/csrspmv_checker.sv
// ----------------------------------------------------------------------------
// csrspmv_checker
// Port-level checks of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "csr_sparse_matrix_vector_multiply_macros.svh"

module csrspmv_checker
  import csrspmv_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [OP_W-1:0]       s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  logic s_fire;
  logic nonzero_fire;
  logic load_fire;
  logic sum_at_limit;

  assign s_fire       = s_axis_tvalid && s_axis_tready;
  assign nonzero_fire = s_fire && (s_axis_tuser == OP_NONZERO);
  assign load_fire    = s_fire && (s_axis_tuser == OP_LOAD);
  assign sum_at_limit = (m_axis_tdata[ROW_W+VALUE_W-1:ROW_W] == SUM_MAX[VALUE_W-1:0]) ||
                        (m_axis_tdata[ROW_W+VALUE_W-1:ROW_W] == SUM_MIN[VALUE_W-1:0]);

  `CSMV_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CSMV_ASSERT_NOW(a_sat_clip, clk, rst, m_axis_tvalid && m_axis_tuser, sum_at_limit)
  `CSMV_ASSERT_NEXT(a_nonzero_busy, clk, rst, nonzero_fire, !s_axis_tready)
  `CSMV_ASSERT_NEXT(a_load_silent, clk, rst, load_fire && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind csr_sparse_matrix_vector_multiply csrspmv_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
